[design/wfp_pkg.sv]
// Shared types and constants of the wall-follow PID steering block.
// Depends on nothing; every other design file uses it.
package wfp_pkg;

    localparam int DIST_W     = 16;
    localparam int TIME_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int MM_W       = 12;
    localparam int LIM_W      = 10;
    localparam int DEG_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int ERR_W      = 13;   // signed distance error, |e| <= 4095
    localparam int DELTA_W    = 14;   // signed change of the error
    localparam int PROD_W     = 28;   // |error| * dt
    localparam int DMUL_W     = 23;   // |delta| * 1000
    localparam int STEP_W     = 9;    // saturated steering step magnitude

    localparam logic [TIME_W-1:0] MS_PER_S = 16'd1000;

    localparam logic [CFG_IDX_W-1:0] CFG_KP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ILIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SRV_MIN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SRV_MAX = 3'd7;

    localparam logic [GAIN_W-1:0] KP_RESET     = 16'd18350;
    localparam logic [GAIN_W-1:0] KI_RESET     = 16'd393;
    localparam logic [GAIN_W-1:0] KD_RESET     = 16'd3604;
    localparam logic [MM_W-1:0]   TARGET_RESET = 12'd100;
    localparam logic [LIM_W-1:0]  ILIMIT_RESET = 10'd300;
    localparam logic [MM_W-1:0]   TURN_RESET   = 12'd400;
    localparam logic [DEG_W-1:0]  SRV_MIN_RESET = 8'd60;
    localparam logic [DEG_W-1:0]  SRV_MAX_RESET = 8'd120;
    localparam logic [DEG_W-1:0]  CENTER_RESET  = 8'd90;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIVI_GO,
        S_DIVI,
        S_DIVD_GO,
        S_DIVD,
        S_MUL_GO,
        S_MUL,
        S_FIN,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        TERM_P,
        TERM_I,
        TERM_D
    } t_term;

endpackage

[design/wfp_in_if.sv]
// Input channel of the steering block: one distance reading per beat.
// Depends on wfp_pkg for the field widths.
interface wfp_in_if;
    logic                        valid;
    logic                        ready;
    logic [wfp_pkg::DIST_W-1:0]  distance_mm;
    logic                        reading_fresh;
    logic [wfp_pkg::TIME_W-1:0]  elapsed_ms;
    logic                        follow_right;

    modport source (output valid, distance_mm, reading_fresh, elapsed_ms, follow_right,
                    input ready);
    modport sink   (input valid, distance_mm, reading_fresh, elapsed_ms, follow_right,
                    output ready);
endinterface

[design/wfp_out_if.sv]
// Output channel of the steering block: one servo command per beat.
// Depends on wfp_pkg for the field widths.
interface wfp_out_if;
    logic                       valid;
    logic                       ready;
    logic [wfp_pkg::DEG_W-1:0]  servo_angle;
    logic                       turn_request;

    modport source (output valid, servo_angle, turn_request, input ready);
    modport sink   (input valid, servo_angle, turn_request, output ready);
endinterface

[design/wfp_div.sv]
// Bit-serial restoring divider: one quotient bit per clock, 16-bit divisor.
// Depends on wfp_pkg for the divisor width.
module wfp_div #(
    parameter int DW = 44
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [DW-1:0]                i_dividend,
    input  logic [wfp_pkg::TIME_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [DW-1:0]                o_quotient
);
    import wfp_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [TIME_W-1:0] r_rem;
    logic [TIME_W-1:0] r_div;
    logic [DW-1:0]     r_q;
    logic [TIME_W:0]   trial;
    logic [TIME_W:0]   diff;
    logic              fits;

    // The dividend shifts out of the top of r_q while quotient bits enter at the bottom.
    assign trial = {r_rem, r_q[DW-1]};
    assign diff  = trial - {1'b0, r_div};
    assign fits  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
            r_q   <= {r_q[DW-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;
endmodule

[design/wfp_mac.sv]
// Bit-serial multiplier: signed operand times 16-bit unsigned gain, gain MSB first.
// Depends on wfp_pkg for the gain width.
module wfp_mac #(
    parameter int XW = 45
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [XW-1:0]              i_x,
    input  logic [wfp_pkg::GAIN_W-1:0]        i_gain,
    output logic                              o_done,
    output logic signed [XW+wfp_pkg::GAIN_W:0] o_product
);
    import wfp_pkg::*;

    localparam int PW = XW + GAIN_W + 1;
    localparam int CW = $clog2(GAIN_W + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CW-1:0]        r_cnt;
    logic [GAIN_W-1:0]    r_g;
    logic signed [XW-1:0] r_x;
    logic signed [PW-1:0] r_p;
    logic signed [PW-1:0] addend;

    assign addend = r_g[GAIN_W-1] ? {{(PW-XW){r_x[XW-1]}}, r_x} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(GAIN_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_p <= '0;
            r_g <= i_gain;
            r_x <= i_x;
        end else if (r_busy) begin
            r_p <= (r_p <<< 1) + addend;
            r_g <= {r_g[GAIN_W-2:0], 1'b0};
        end
    end

    assign o_done    = r_done;
    assign o_product = r_p;
endmodule

[design/wall_follow_pid_steering.sv]
// Top level of the wall-follow PID steering block.
// Depends on wfp_pkg, wfp_in_if, wfp_out_if, wfp_div and wfp_mac.

// One beat in gives one beat out. A stale reading, or a distance beyond the
// turn threshold, returns the held servo angle with a turn request and leaves
// the controller state alone. A valid reading runs the PID update: the integral
// increment and the derivative each take one pass of a shared bit-serial
// divider, and the three gain products each take one pass of a bit-serial
// multiplier. The block takes one beat at a time; the result sits in an output
// register, and the next beat is taken as soon as the result has been loaded
// there. Configuration registers are written through a simple write port and
// should only change while idle.
module wall_follow_pid_steering #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [wfp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [wfp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    wfp_in_if.sink                           i_in,
    wfp_out_if.source                        o_out
);
    import wfp_pkg::*;

    localparam int DW = PROD_W + FRAC_BITS;       // divider dividend width
    localparam int XW = DW + 1;                   // signed multiplier operand
    localparam int PW = XW + GAIN_W + 1;          // signed product
    localparam int SW = PW + 2;                   // signed sum of three products
    localparam int AW = LIM_W + 1 + FRAC_BITS;    // signed integral accumulator
    localparam int SH = GAIN_W + FRAC_BITS;       // scale of the sum

    // Configuration registers.
    logic [GAIN_W-1:0] r_kp, r_ki, r_kd;
    logic [MM_W-1:0]   r_target, r_turn;
    logic [LIM_W-1:0]  r_lim;
    logic [DEG_W-1:0]  r_smin, r_smax;

    // Controller state.
    logic signed [AW-1:0]    r_integ;
    logic signed [ERR_W-1:0] r_prev_err;
    logic [DEG_W-1:0]        r_held;

    // Per-beat working registers.
    t_state              r_state, n_state;
    t_term               r_term;
    logic                r_right, r_eneg, r_dneg;
    logic [MM_W-1:0]     r_emag;
    logic [ERR_W-1:0]    r_dmag;
    logic [TIME_W-1:0]   r_dt;
    logic [DW-1:0]       r_deriv;
    logic signed [SW-1:0] r_sum;
    logic [DEG_W-1:0]    r_res_angle;
    logic                r_res_turn;

    // Output register.
    logic               r_ov;
    logic [DEG_W-1:0]   r_oangle;
    logic               r_oturn;

    // Handshake and strobes.
    logic in_fire, out_load, div_start, mac_start;
    logic div_done, mac_done;
    logic [DW-1:0] div_q;
    logic signed [PW-1:0] mac_p;

    // Beat decode.
    logic signed [ERR_W-1:0]   err_c;
    logic signed [DELTA_W-1:0] delta_c;
    logic                      turn_c;

    assign in_fire = i_in.valid && i_in.ready;
    assign err_c   = $signed({1'b0, i_in.distance_mm[MM_W-1:0]}) - $signed({1'b0, r_target});
    assign delta_c = DELTA_W'(err_c) - DELTA_W'(r_prev_err);
    assign turn_c  = !i_in.reading_fresh || (i_in.distance_mm > {4'b0, r_turn});

    // Divider operands: integral increment first, then the derivative.
    logic [PROD_W-1:0] prod_i;
    logic [DMUL_W-1:0] prod_d;
    logic [DW-1:0]     div_dividend;
    logic [TIME_W-1:0] div_divisor;

    assign prod_i = {16'b0, r_emag} * {12'b0, r_dt};
    assign prod_d = {10'b0, r_dmag} * {7'b0, MS_PER_S};
    assign div_dividend = (r_state == S_DIVI_GO)
                        ? {prod_i, {FRAC_BITS{1'b0}}}
                        : {{(PROD_W-DMUL_W){1'b0}}, prod_d, {FRAC_BITS{1'b0}}};
    assign div_divisor  = (r_state == S_DIVI_GO) ? MS_PER_S : r_dt;

    wfp_div #(.DW(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Integral update with the symmetric clamp, done as the increment arrives.
    logic signed [DW:0]   inc_s;
    logic signed [DW+1:0] integ_sum;
    logic signed [DW+1:0] lim_pos;
    logic signed [DW+1:0] integ_clamped;

    assign inc_s     = r_eneg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    assign integ_sum = $signed({{(DW+2-AW){r_integ[AW-1]}}, r_integ}) + (DW+2)'(inc_s);
    assign lim_pos   = $signed((DW+2)'({r_lim, {FRAC_BITS{1'b0}}}));

    always_comb begin
        integ_clamped = integ_sum;
        if (integ_sum > lim_pos) begin
            integ_clamped = lim_pos;
        end
        if (integ_sum < -lim_pos) begin
            integ_clamped = -lim_pos;
        end
    end

    // Multiplier operand and gain for the current term.
    logic signed [XW-1:0] p_mag, d_mag, mac_x;
    logic [GAIN_W-1:0]    mac_gain;

    assign p_mag = $signed(XW'({r_emag, {FRAC_BITS{1'b0}}}));
    assign d_mag = $signed({1'b0, r_deriv});

    always_comb begin
        case (r_term)
            TERM_P: begin
                mac_x    = r_eneg ? -p_mag : p_mag;
                mac_gain = r_kp;
            end
            TERM_I: begin
                mac_x    = {{(XW-AW){r_integ[AW-1]}}, r_integ};
                mac_gain = r_ki;
            end
            TERM_D: begin
                mac_x    = r_dneg ? -d_mag : d_mag;
                mac_gain = r_kd;
            end
            default: begin
                mac_x    = '0;
                mac_gain = '0;
            end
        endcase
    end

    wfp_mac #(.XW(XW)) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mac_start),
        .i_x       (mac_x),
        .i_gain    (mac_gain),
        .o_done    (mac_done),
        .o_product (mac_p)
    );

    // Final scaling: side sign, truncation toward zero, center offset, clamp.
    // The step saturates at 511, which already lies beyond any servo limit.
    logic signed [SW-1:0]     s_side;
    logic [SW-1:0]            s_mag, s_shift;
    logic [STEP_W-1:0]        step_mag;
    logic [DEG_W:0]           center;
    logic signed [DEG_W+2:0]  angle_raw, angle_min, angle_fin;

    assign s_side   = r_right ? r_sum : -r_sum;
    assign s_mag    = s_side[SW-1] ? -s_side : s_side;
    assign s_shift  = s_mag >> SH;
    assign step_mag = (|s_shift[SW-1:STEP_W]) ? {STEP_W{1'b1}} : s_shift[STEP_W-1:0];
    assign center   = ({1'b0, r_smin} + {1'b0, r_smax}) >> 1;
    assign angle_raw = s_side[SW-1]
                     ? $signed({2'b0, center}) - $signed({2'b0, step_mag})
                     : $signed({2'b0, center}) + $signed({2'b0, step_mag});

    always_comb begin
        angle_min = angle_raw;
        if (angle_raw < $signed({3'b0, r_smin})) begin
            angle_min = $signed({3'b0, r_smin});
        end
        angle_fin = angle_min;
        if (angle_min > $signed({3'b0, r_smax})) begin
            angle_fin = $signed({3'b0, r_smax});
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        mac_start = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = turn_c ? S_OUT : S_DIVI_GO;
                end
            end
            S_DIVI_GO: begin
                div_start = 1'b1;
                n_state   = S_DIVI;
            end
            S_DIVI: begin
                if (div_done) begin
                    n_state = S_DIVD_GO;
                end
            end
            S_DIVD_GO: begin
                div_start = 1'b1;
                n_state   = S_DIVD;
            end
            S_DIVD: begin
                if (div_done) begin
                    n_state = S_MUL_GO;
                end
            end
            S_MUL_GO: begin
                mac_start = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                if (mac_done) begin
                    n_state = (r_term == TERM_D) ? S_FIN : S_MUL_GO;
                end
            end
            S_FIN: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ov || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Configuration writes; an unused index is simply ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp     <= KP_RESET;
            r_ki     <= KI_RESET;
            r_kd     <= KD_RESET;
            r_target <= TARGET_RESET;
            r_lim    <= ILIMIT_RESET;
            r_turn   <= TURN_RESET;
            r_smin   <= SRV_MIN_RESET;
            r_smax   <= SRV_MAX_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KP:      r_kp     <= i_cfg_data;
                CFG_KI:      r_ki     <= i_cfg_data;
                CFG_KD:      r_kd     <= i_cfg_data;
                CFG_TARGET:  r_target <= i_cfg_data[MM_W-1:0];
                CFG_ILIMIT:  r_lim    <= i_cfg_data[LIM_W-1:0];
                CFG_TURN:    r_turn   <= i_cfg_data[MM_W-1:0];
                CFG_SRV_MIN: r_smin   <= i_cfg_data[DEG_W-1:0];
                CFG_SRV_MAX: r_smax   <= i_cfg_data[DEG_W-1:0];
                default: ;
            endcase
        end
    end

    // Controller state: only a PID beat changes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ    <= '0;
            r_prev_err <= '0;
            r_held     <= CENTER_RESET;
        end else begin
            if (in_fire && (r_state == S_IDLE) && !turn_c) begin
                r_prev_err <= err_c;
            end
            if ((r_state == S_DIVI) && div_done) begin
                r_integ <= AW'(integ_clamped);
            end
            if (r_state == S_FIN) begin
                r_held <= angle_fin[DEG_W-1:0];
            end
        end
    end

    // Beat working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term <= TERM_P;
        end else begin
            if (in_fire && (r_state == S_IDLE)) begin
                r_term <= TERM_P;
            end else if ((r_state == S_MUL) && mac_done && (r_term != TERM_D)) begin
                r_term <= (r_term == TERM_P) ? TERM_I : TERM_D;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && (r_state == S_IDLE)) begin
            r_right     <= i_in.follow_right;
            r_eneg      <= err_c[ERR_W-1];
            r_emag      <= err_c[ERR_W-1] ? MM_W'(-err_c) : err_c[MM_W-1:0];
            r_dneg      <= delta_c[DELTA_W-1];
            r_dmag      <= delta_c[DELTA_W-1] ? ERR_W'(-delta_c) : delta_c[ERR_W-1:0];
            r_dt        <= (i_in.elapsed_ms == '0) ? TIME_W'(1) : i_in.elapsed_ms;
            r_sum       <= '0;
            r_res_angle <= r_held;
            r_res_turn  <= turn_c;
        end
        if ((r_state == S_DIVD) && div_done) begin
            r_deriv <= div_q;
        end
        if ((r_state == S_MUL) && mac_done) begin
            r_sum <= r_sum + {{(SW-PW){mac_p[PW-1]}}, mac_p};
        end
        if (r_state == S_FIN) begin
            r_res_angle <= angle_fin[DEG_W-1:0];
            r_res_turn  <= 1'b0;
        end
    end

    // Output register: the result waits here until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_oangle <= r_res_angle;
            r_oturn  <= r_res_turn;
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_ov;
    assign o_out.servo_angle  = r_oangle;
    assign o_out.turn_request = r_oturn;
endmodule

[tb/sv/tb_wall_follow_pid_steering.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the wall-follow PID steering block.
// Depends on wfp_pkg, wfp_in_if, wfp_out_if and the wall_follow_pid_steering RTL.

typedef struct {
    logic [wfp_pkg::DIST_W-1:0] distance_mm;
    logic                       reading_fresh;
    logic [wfp_pkg::TIME_W-1:0] elapsed_ms;
    logic                       follow_right;
} t_reading;

typedef struct {
    logic [wfp_pkg::DEG_W-1:0] servo_angle;
    logic                      turn_request;
} t_command;

// Keeps a private copy of the registers and the controller state, works out
// the servo command of each accepted reading and checks the commands that
// come out, oldest first.
class steering_scoreboard;
    localparam int FRAC = 16;

    logic [15:0] kp, ki, kd;
    logic [11:0] target_mm, turn_mm;
    logic [9:0]  ilimit;
    logic [7:0]  srv_min, srv_max, held_angle;
    longint      integral_acc;
    longint      prev_error;
    t_command    expected_cmds[$];
    int          errors;

    function void reset_state();
        kp = wfp_pkg::KP_RESET;
        ki = wfp_pkg::KI_RESET;
        kd = wfp_pkg::KD_RESET;
        target_mm = wfp_pkg::TARGET_RESET;
        ilimit = wfp_pkg::ILIMIT_RESET;
        turn_mm = wfp_pkg::TURN_RESET;
        srv_min = wfp_pkg::SRV_MIN_RESET;
        srv_max = wfp_pkg::SRV_MAX_RESET;
        held_angle = wfp_pkg::CENTER_RESET;
        integral_acc = 0;
        prev_error = 0;
        errors = 0;
    endfunction

    // Only the low bits that fit the register are kept.
    function void write_reg(logic [2:0] idx, logic [15:0] data);
        case (idx)
            wfp_pkg::CFG_KP:      kp = data;
            wfp_pkg::CFG_KI:      ki = data;
            wfp_pkg::CFG_KD:      kd = data;
            wfp_pkg::CFG_TARGET:  target_mm = data[11:0];
            wfp_pkg::CFG_ILIMIT:  ilimit = data[9:0];
            wfp_pkg::CFG_TURN:    turn_mm = data[11:0];
            wfp_pkg::CFG_SRV_MIN: srv_min = data[7:0];
            wfp_pkg::CFG_SRV_MAX: srv_max = data[7:0];
            default: ;
        endcase
    endfunction

    function t_command steer(t_reading r);
        t_command c;
        longint dt, err, emag, inc, lim, delta, dmag, derivmag;
        longint pterm, iterm, dterm, sum, smag, stp, center, angle;
        if (!r.reading_fresh || r.distance_mm > turn_mm) begin
            c.servo_angle = held_angle;
            c.turn_request = 1'b1;
            return c;
        end
        dt = (r.elapsed_ms == 0) ? 1 : longint'(r.elapsed_ms);
        err = longint'(r.distance_mm) - longint'(target_mm);
        emag = (err < 0) ? -err : err;
        inc = ((emag * dt) <<< FRAC) / 1000;
        integral_acc += (err < 0) ? -inc : inc;
        lim = longint'(ilimit) <<< FRAC;
        if (integral_acc > lim) integral_acc = lim;
        if (integral_acc < -lim) integral_acc = -lim;
        delta = err - prev_error;
        prev_error = err;
        dmag = (delta < 0) ? -delta : delta;
        derivmag = ((dmag * 1000) <<< FRAC) / dt;
        pterm = (longint'(kp) * emag) <<< FRAC;
        if (err < 0) pterm = -pterm;
        iterm = longint'(ki) * integral_acc;
        dterm = longint'(kd) * derivmag;
        if (delta < 0) dterm = -dterm;
        sum = pterm + iterm + dterm;
        if (!r.follow_right) sum = -sum;
        smag = (sum < 0) ? -sum : sum;
        stp = smag >>> (16 + FRAC);
        if (sum < 0) stp = -stp;
        center = (longint'(srv_min) + longint'(srv_max)) / 2;
        angle = center + stp;
        if (angle < longint'(srv_min)) angle = srv_min;
        if (angle > longint'(srv_max)) angle = srv_max;
        held_angle = angle[7:0];
        c.servo_angle = held_angle;
        c.turn_request = 1'b0;
        return c;
    endfunction

    function void note_reading(t_reading r);
        expected_cmds.push_back(steer(r));
    endfunction

    function void check_command(logic [7:0] angle, logic turn);
        t_command e;
        if (expected_cmds.size() == 0) begin
            $error("servo command with none expected: angle %0d, turn %0d", angle, turn);
            errors++;
            return;
        end
        e = expected_cmds.pop_front();
        if (angle !== e.servo_angle) begin
            $error("servo_angle: expected %0d, actual %0d", e.servo_angle, angle);
            errors++;
        end
        if (turn !== e.turn_request) begin
            $error("turn_request: expected %0d, actual %0d", e.turn_request, turn);
            errors++;
        end
    endfunction
endclass

module tb_wall_follow_pid_steering;
    import wfp_pkg::*;

    localparam longint CYCLE_LIMIT = 4_000_000;
    // Settling time of drain(); it covers any work still in flight.
    localparam int DRAIN_CYCLES = 400;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    wfp_in_if  in_ch ();
    wfp_out_if out_ch ();

    wall_follow_pid_steering dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    steering_scoreboard sb = new();

    // Idle rates of the two sides in percent, and the long receiver hold-off.
    int     tx_idle_pct = 0;
    int     rx_idle_pct = 0;
    bit     hold_req = 0;
    int     hold_left = 0;
    longint cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver either stalls at random or, once asked, holds off for a long
    // stretch so that the block fills up and has to refuse input beats.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_ch.ready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 0;
            hold_left = 700;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Every output beat is checked against the oldest expected command.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_command(out_ch.servo_angle, out_ch.turn_request);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Offers one reading, with a random gap before it, and waits for the beat.
    // Valid stays high into the next reading when there is no gap.
    task automatic send_reading(t_reading r);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.distance_mm   <= r.distance_mm;
        in_ch.reading_fresh <= r.reading_fresh;
        in_ch.elapsed_ms    <= r.elapsed_ms;
        in_ch.follow_right  <= r.follow_right;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_reading(r);
    endtask

    task automatic send_fields(int mm, bit fresh, int ms, bit right);
        t_reading r;
        r.distance_mm = DIST_W'(mm);
        r.reading_fresh = fresh;
        r.elapsed_ms = TIME_W'(ms);
        r.follow_right = right;
        send_reading(r);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // Waits until every expected command has arrived, then lets the block settle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.expected_cmds.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_settings(int kp, int ki, int kd, int tgt, int lim, int turn,
                                 int smin, int smax);
        write_reg(CFG_KP, CFG_DATA_W'(kp));
        write_reg(CFG_KI, CFG_DATA_W'(ki));
        write_reg(CFG_KD, CFG_DATA_W'(kd));
        write_reg(CFG_TARGET, CFG_DATA_W'(tgt));
        write_reg(CFG_ILIMIT, CFG_DATA_W'(lim));
        write_reg(CFG_TURN, CFG_DATA_W'(turn));
        write_reg(CFG_SRV_MIN, CFG_DATA_W'(smin));
        write_reg(CFG_SRV_MAX, CFG_DATA_W'(smax));
    endtask

    // Most readings land on the PID path; the rest are stale or too far, and
    // some carry a fully random distance so every bit toggles.
    task automatic random_readings(int count);
        int mm, ms, pick;
        bit fresh;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 75)
                mm = $urandom_range(sb.turn_mm, 0);
            else if (pick < 90)
                mm = $urandom_range(16'hFFFF, 0);
            else
                mm = sb.turn_mm + $urandom_range(3, 0);
            fresh = ($urandom_range(99) < 90);
            pick = $urandom_range(99);
            if (pick < 15)
                ms = 0;
            else if (pick < 65)
                ms = $urandom_range(100, 1);
            else
                ms = $urandom_range(16'hFFFF, 0);
            send_fields(mm, fresh, ms, 1'($urandom_range(1)));
        end
    endtask

    initial begin
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = '0;
        i_cfg_data          = '0;
        in_ch.valid         = 1'b0;
        in_ch.distance_mm   = '0;
        in_ch.reading_fresh = 1'b0;
        in_ch.elapsed_ms    = '0;
        in_ch.follow_right  = 1'b0;
        out_ch.ready        = 1'b0;
        sb.reset_state();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed readings at the reset settings: threshold edges, the absent
        // sensor value, stale input, zero and huge elapsed times, both sides,
        // and a run of large errors that drives the integral into its clamp.
        send_fields(0, 1, 20, 1);
        send_fields(100, 1, 20, 1);
        send_fields(400, 1, 0, 1);
        send_fields(401, 1, 20, 0);
        send_fields(16'hFFFF, 1, 20, 1);
        send_fields(9999, 1, 20, 0);
        send_fields(50, 0, 20, 1);
        send_fields(150, 1, 1, 0);
        send_fields(400, 1, 16'hFFFF, 1);
        send_fields(400, 1, 16'hFFFF, 1);
        send_fields(400, 1, 16'hFFFF, 0);
        send_fields(0, 1, 16'hFFFF, 0);
        send_fields(0, 1, 16'hFFFF, 1);
        send_fields(399, 1, 0, 0);
        send_fields(120, 0, 0, 1);
        send_fields(90, 1, 33, 0);
        drain();

        // Each setting runs a slice of random readings. The idle pattern moves
        // from a slow receiver, to a slow sender, to no idling at all.
        for (int k = 0; k < 6; k++) begin
            case (k)
                0: load_settings(KP_RESET, KI_RESET, KD_RESET, 16'hF064, 16'hFD2C,
                                 16'hF190, SRV_MIN_RESET, SRV_MAX_RESET);
                1: load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 1023, 4095, 0, 180);
                2: load_settings(0, 0, 0, 4095, 0, 4095, 180, 0);
                3: load_settings($urandom_range(16'hFFFF), $urandom_range(16'hFFFF),
                                 $urandom_range(16'hFFFF), 200, 5, 600, 30, 150);
                4: load_settings(1000, 16'hFFFF, 100, 2000, 1023, 3000, 45, 135);
                default: load_settings($urandom_range(16'hFFFF), $urandom_range(16'hFFFF),
                                       $urandom_range(16'hFFFF), $urandom_range(4095),
                                       $urandom_range(1023), $urandom_range(4095, 300),
                                       $urandom_range(180), $urandom_range(180));
            endcase
            if (k < 2) begin
                tx_idle_pct = 22;
                rx_idle_pct = 88;
            end else if (k < 4) begin
                tx_idle_pct = 88;
                rx_idle_pct = 22;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (k == 5) hold_req = 1;
            random_readings(200);
            drain();
        end

        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
